// ===== sv/stbs_pkg.sv =====
package stbs_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int STAT_W = 2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [STAT_W-1:0]        status_t;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam status_t ST_FOUND     = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_NOT_READY = 2'd2;

    // Result of the shared signed comparator: x < y and x == y.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

// ===== sv/stbs_mem.sv =====
module stbs_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  stbs_pkg::data_t       wdata,
    input  logic [AW-1:0]         raddr,
    output stbs_pkg::data_t       rdata
);

    stbs_pkg::data_t mem [DEPTH];
    stbs_pkg::data_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/stbs_cmp.sv =====
module stbs_cmp (
    input  stbs_pkg::data_t    x,
    input  stbs_pkg::data_t    y,
    output stbs_pkg::cmp_res_t res
);

    always_comb begin
        res.lt = (x < y);
        res.eq = (x == y);
    end

endmodule

// ===== sv/stbs_seq.sv =====
module stbs_seq #(
    parameter int TABLE_SIZE = 16,
    parameter int IW         = 4,
    parameter int CW         = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_opcode,
    input  stbs_pkg::data_t         s_value,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output stbs_pkg::status_t       m_status,
    output stbs_pkg::pos_t          m_position,
    output logic                    mem_we,
    output logic [IW-1:0]           mem_waddr,
    output stbs_pkg::data_t         mem_wdata,
    output logic [IW-1:0]           mem_raddr,
    input  stbs_pkg::data_t         mem_rdata,
    output stbs_pkg::data_t         cmp_x,
    output stbs_pkg::data_t         cmp_y,
    input  stbs_pkg::cmp_res_t      cmp_res
);

    localparam logic [2:0] IDLE  = 3'd0;
    localparam logic [2:0] S_ADR = 3'd1;
    localparam logic [2:0] S_CMP = 3'd2;
    localparam logic [2:0] T_RDI = 3'd3;
    localparam logic [2:0] T_RDJ = 3'd4;
    localparam logic [2:0] T_CMP = 3'd5;
    localparam logic [2:0] T_WRI = 3'd6;
    localparam logic [2:0] RESP  = 3'd7;

    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_SIZE);
    localparam logic [IW-1:0] LAST_J   = IW'(TABLE_SIZE - 1);
    localparam logic [IW-1:0] LAST_I   = IW'(TABLE_SIZE - 2);

    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [IW-1:0]           i_reg, i_next;
    logic [IW-1:0]           j_reg, j_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hip_reg, hip_next;
    logic [IW-1:0]           mid_reg, mid_next;
    stbs_pkg::data_t         hold_reg, hold_next;
    stbs_pkg::status_t       res_status_reg, res_status_next;
    stbs_pkg::pos_t          res_pos_reg, res_pos_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    stbs_pkg::status_t       m_status_reg, m_status_next;
    stbs_pkg::pos_t          m_pos_reg, m_pos_next;

    logic [CW-1:0]           load_base;
    logic [CW:0]             mid_sum;
    logic [IW-1:0]           mid_calc;

    // The upper bound is held as high + 1, so an empty range never goes negative.
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hip_reg} - (CW+1)'(1);
    assign mid_calc  = mid_sum[IW:1];
    assign load_base = (fill_reg == FULL_CNT) ? '0 : fill_reg;

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        lo_next         = lo_reg;
        hip_next        = hip_reg;
        mid_next        = mid_reg;
        hold_next       = hold_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_pos_next      = m_pos_reg;
        mem_we          = 1'b0;
        mem_waddr       = j_reg;
        mem_wdata       = hold_reg;
        mem_raddr       = j_reg;
        cmp_x           = hold_reg;
        cmp_y           = mem_rdata;

        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    if (s_opcode == stbs_pkg::OP_LOAD) begin
                        mem_we    = 1'b1;
                        mem_waddr = load_base[IW-1:0];
                        mem_wdata = s_value;
                        fill_next = load_base + 1'b1;
                        if (load_base + 1'b1 == FULL_CNT) begin
                            i_next     = '0;
                            state_next = T_RDI;
                        end
                    end else if (fill_reg != FULL_CNT) begin
                        res_status_next = stbs_pkg::ST_NOT_READY;
                        res_pos_next    = '0;
                        state_next      = RESP;
                    end else begin
                        hold_next  = s_value;
                        lo_next    = '0;
                        hip_next   = FULL_CNT;
                        state_next = S_ADR;
                    end
                end
            end
            S_ADR: begin
                if (lo_reg < hip_reg) begin
                    mem_raddr  = mid_calc;
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end else begin
                    res_status_next = stbs_pkg::ST_NOT_FOUND;
                    res_pos_next    = '0;
                    state_next      = RESP;
                end
            end
            S_CMP: begin
                cmp_x = hold_reg;
                cmp_y = mem_rdata;
                if (cmp_res.eq) begin
                    res_status_next = stbs_pkg::ST_FOUND;
                    res_pos_next    = stbs_pkg::pos_t'(mid_reg);
                    state_next      = RESP;
                end else if (cmp_res.lt) begin
                    hip_next   = CW'(mid_reg);
                    state_next = S_ADR;
                end else begin
                    lo_next    = CW'(mid_reg) + 1'b1;
                    state_next = S_ADR;
                end
            end
            T_RDI: begin
                mem_raddr  = i_reg;
                state_next = T_RDJ;
            end
            T_RDJ: begin
                hold_next  = mem_rdata;
                j_next     = IW'(i_reg + 1'b1);
                mem_raddr  = IW'(i_reg + 1'b1);
                state_next = T_CMP;
            end
            T_CMP: begin
                // The live value of slot i stays in the hold register; only the
                // later slot is written back on an exchange.
                cmp_x = mem_rdata;
                cmp_y = hold_reg;
                if (cmp_res.lt) begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg;
                    mem_wdata = hold_reg;
                    hold_next = mem_rdata;
                end
                if (j_reg == LAST_J) begin
                    state_next = T_WRI;
                end else begin
                    j_next    = IW'(j_reg + 1'b1);
                    mem_raddr = IW'(j_reg + 1'b1);
                end
            end
            T_WRI: begin
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = hold_reg;
                if (i_reg == LAST_I) begin
                    state_next = IDLE;
                end else begin
                    i_next     = IW'(i_reg + 1'b1);
                    state_next = T_RDI;
                end
            end
            RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_pos_next    = res_pos_reg;
                    state_next    = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        lo_reg         <= lo_next;
        hip_reg        <= hip_next;
        mid_reg        <= mid_next;
        hold_reg       <= hold_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        m_status_reg   <= m_status_next;
        m_pos_reg      <= m_pos_next;
    end

    assign s_tready   = (state_reg == IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_status   = m_status_reg;
    assign m_position = m_pos_reg;

endmodule

// ===== sv/sorted_table_binary_search.sv =====
// Sorted table with binary search.
// Input channel s_*: each transfer is either a load (s_tuser = 0) that writes
// s_tdata into the next table slot, or a search (s_tuser = 1) for the key in
// s_tdata. Loads give no result; every search gives one result on m_*.
// m_tuser carries the status (found, not found, table not fully loaded) and
// m_tdata the zero-based position of the match, or zero.
// Once the last slot is loaded the table is sorted in place by an exchange
// sort that compares each slot in turn with every later slot.
// A load into a full table starts a new one.
// A search probes one midpoint at a time: it sets the address, then compares
// the key against the registered memory read; a search before the table is
// full answers not ready without probing. A load that does not complete the
// table leaves the sequencer idle. The sort and the search share the single
// comparator and the single memory read port.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; while the receiver stalls, new loads
// are still taken, and a further search waits until the register is free.
// Synchronous reset empties the table and drops any pending result.
module sorted_table_binary_search #(
    parameter int TABLE_SIZE = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] position, [7:4] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);

    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    stbs_pkg::data_t        mem_wdata;
    logic [IW-1:0]          mem_raddr;
    stbs_pkg::data_t        mem_rdata;
    stbs_pkg::data_t        cmp_x;
    stbs_pkg::data_t        cmp_y;
    stbs_pkg::cmp_res_t     cmp_res;
    stbs_pkg::status_t      status;
    stbs_pkg::pos_t         position;

    stbs_mem #(
        .DEPTH (TABLE_SIZE),
        .AW    (IW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    stbs_cmp u_cmp (
        .x   (cmp_x),
        .y   (cmp_y),
        .res (cmp_res)
    );

    stbs_seq #(
        .TABLE_SIZE (TABLE_SIZE),
        .IW         (IW),
        .CW         (CW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_opcode   (s_tuser[0]),
        .s_value    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_status   (status),
        .m_position (position),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .cmp_x      (cmp_x),
        .cmp_y      (cmp_y),
        .cmp_res    (cmp_res)
    );

    assign m_tdata = {4'b0000, position};
    assign m_tuser = status;

endmodule

// ===== sv/stbs_checker.sv =====
module stbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser
);

    // A held result must not change until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == stbs_pkg::ST_FOUND || m_tuser == stbs_pkg::ST_NOT_FOUND
                      || m_tuser == stbs_pkg::ST_NOT_READY))
        else $error("invalid status code");

    // Only a hit carries a position.
    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != stbs_pkg::ST_FOUND |-> m_tdata == 8'd0)
        else $error("position set on a miss");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
